@@ sv/serial_command_frame_parser_unit_assert.svh @@
// Assertion macros used by the frame parser RTL.
`ifndef SERIAL_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SCFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame parser check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SCFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame parser check failed");

`endif

@@ sv/scfp_pkg.sv @@
// Package: constants and types of the serial command frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

  // Argument bytes kept per frame; commands read only the first ARGS_USED.
  localparam int STORED_ARGS = 8;
  localparam int ARG_IDX_W   = (STORED_ARGS > 1) ? $clog2(STORED_ARGS) : 1;
  localparam int ARGS_USED   = 5;

  // Parse phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_CMD   = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_ARGS  = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;

  // Frame status codes
  localparam logic [2:0] ST_NONE    = 3'd0;
  localparam logic [2:0] ST_APPLIED = 3'd1;
  localparam logic [2:0] ST_BADCHK  = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_START_BYTE   = 3'd0;
  localparam logic [2:0] REG_OP_LED       = 3'd1;
  localparam logic [2:0] REG_OP_ADC       = 3'd2;
  localparam logic [2:0] REG_OP_DAC       = 3'd3;
  localparam logic [2:0] REG_OP_SERIAL    = 3'd4;
  localparam logic [2:0] REG_OP_SD        = 3'd5;
  localparam logic [2:0] REG_CHECK_ENABLE = 3'd6;

  // Minimum argument counts per command
  localparam logic [7:0] LED_ARGS    = 8'd2;
  localparam logic [7:0] ADC_ARGS    = 8'd5;
  localparam logic [7:0] DAC_ARGS    = 8'd3;
  localparam logic [7:0] SERIAL_ARGS = 8'd1;
  localparam logic [7:0] SD_ARGS     = 8'd1;

  localparam logic [31:0] PERIOD_LIMIT = 32'd1000000000;
  localparam logic [29:0] PERIOD_RESET = 30'd1000;
  localparam logic [7:0]  LED_COUNT    = 8'd4;
  localparam logic [7:0]  CHANNEL_COUNT = 8'd8;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] op_led;
    logic [7:0] op_adc;
    logic [7:0] op_dac;
    logic [7:0] op_serial;
    logic [7:0] op_sd;
    logic       check_enable;
  } cfg_t;

  // Completed frame handed to the decoder
  typedef struct packed {
    logic [7:0]                     command;
    logic [7:0]                     arg_length;
    logic [ARGS_USED-1:0][7:0]      args;
    logic [7:0]                     xor_final;
  } frame_t;

  // Decoder verdict and register updates
  typedef struct packed {
    logic [2:0]  status;
    logic        led_write;
    logic [1:0]  led_index;
    logic        led_on;
    logic        channel_we;
    logic [2:0]  channel;
    logic        period_we;
    logic [29:0] period;
    logic        print_we;
    logic        print_val;
    logic        sd_we;
    logic        sd_val;
  } apply_t;

endpackage

@@ sv/scfp_apply.sv @@
// Frame decoder: checks the XOR and turns a completed frame into updates.
`timescale 1ns / 1ps

module scfp_apply (
  input  scfp_pkg::cfg_t   cfg,
  input  scfp_pkg::frame_t frame,
  output scfp_pkg::apply_t result
);

  logic [31:0] period_le;

  assign period_le = {frame.args[4], frame.args[3], frame.args[2], frame.args[1]};

  always_comb begin
    result = '0;
    result.status = scfp_pkg::ST_UNKNOWN;
    result.channel = frame.args[0][2:0];
    result.period = period_le[29:0];
    result.print_val = (frame.args[0] != 8'd0);
    result.sd_val = (frame.args[0] != 8'd0);
    priority if (cfg.check_enable && frame.xor_final != 8'd0) begin
      result.status = scfp_pkg::ST_BADCHK;
    end else if (frame.command == cfg.op_led) begin
      if (frame.arg_length < scfp_pkg::LED_ARGS) begin
        result.status = scfp_pkg::ST_SHORT;
      end else begin
        result.status = scfp_pkg::ST_APPLIED;
        // LED numbers above three are applied but drive nothing
        if (frame.args[0] < scfp_pkg::LED_COUNT) begin
          result.led_write = 1'b1;
          result.led_index = frame.args[0][1:0];
          result.led_on = (frame.args[1] != 8'd0);
        end
      end
    end else if (frame.command == cfg.op_adc) begin
      if (frame.arg_length < scfp_pkg::ADC_ARGS) begin
        result.status = scfp_pkg::ST_SHORT;
      end else begin
        result.status = scfp_pkg::ST_APPLIED;
        result.channel_we = (frame.args[0] < scfp_pkg::CHANNEL_COUNT);
        result.period_we = (period_le != 32'd0) && (period_le < scfp_pkg::PERIOD_LIMIT);
      end
    end else if (frame.command == cfg.op_dac) begin
      result.status = (frame.arg_length < scfp_pkg::DAC_ARGS) ?
                      scfp_pkg::ST_SHORT : scfp_pkg::ST_APPLIED;
    end else if (frame.command == cfg.op_serial) begin
      if (frame.arg_length < scfp_pkg::SERIAL_ARGS) begin
        result.status = scfp_pkg::ST_SHORT;
      end else begin
        result.status = scfp_pkg::ST_APPLIED;
        result.print_we = 1'b1;
      end
    end else if (frame.command == cfg.op_sd) begin
      if (frame.arg_length < scfp_pkg::SD_ARGS) begin
        result.status = scfp_pkg::ST_SHORT;
      end else begin
        result.status = scfp_pkg::ST_APPLIED;
        result.sd_we = 1'b1;
      end
    end else begin
      result.status = scfp_pkg::ST_UNKNOWN;
    end
  end

endmodule

@@ sv/serial_command_frame_parser_unit.sv @@
// Top level: serial command frame parser with config port and result register.
//
// Input channel: in_valid/in_ready carry one received byte (rx_byte) per request.
// Output channel: out_valid/out_ready carry exactly one result per input byte:
// frame flags, frame status, an LED set request and the current ADC channel,
// ADC period, print flag and SD flag as they stand after that byte.
// The result of a byte is registered at the edge that accepts the byte.
// Throughput: one byte per cycle while results are taken. The parse state and
// the result register are updated at the edge that accepts the byte, so bytes
// may stream back to back. When the receiver stalls, the held result keeps
// in_ready low until it is taken; in_ready = !out_valid || out_ready, so a
// result taken in a cycle frees the slot for a new byte in that same cycle.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
// write only while no result is pending.
// Reset (rst, synchronous): parser waits for a start byte, config registers
// take their defaults, ADC channel 0, period 1000, print on, SD off, and the
// output register is empty.
`timescale 1ns / 1ps

module serial_command_frame_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        in_frame,
  output logic        frame_end,
  output logic [2:0]  status,
  output logic        led_write,
  output logic [1:0]  led_index,
  output logic        led_on,
  output logic [2:0]  adc_channel,
  output logic [29:0] adc_period,
  output logic        print_enable,
  output logic        sd_enable
);

  scfp_pkg::cfg_t   cfg;
  scfp_pkg::frame_t frame;
  scfp_pkg::apply_t verdict;

  logic [2:0]  parse_phase, parse_phase_next;
  logic [7:0]  frame_command, frame_command_next;
  logic [7:0]  arg_length, arg_length_next;
  logic [7:0]  arg_count, arg_count_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [2:0]  channel_reg, channel_reg_next;
  logic [29:0] period_reg, period_reg_next;
  logic        print_flag, print_flag_next;
  logic        sd_flag, sd_flag_next;
  logic        frame_active, frame_active_next;
  logic [7:0]  arg_store [scfp_pkg::STORED_ARGS];

  logic        accept;
  logic        store_we;
  logic        is_check;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte   <= 8'd126;
      cfg.op_led       <= 8'd1;
      cfg.op_adc       <= 8'd2;
      cfg.op_dac       <= 8'd3;
      cfg.op_serial    <= 8'd4;
      cfg.op_sd        <= 8'd5;
      cfg.check_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        scfp_pkg::REG_START_BYTE:   cfg.start_byte <= cfg_data;
        scfp_pkg::REG_OP_LED:       cfg.op_led <= cfg_data;
        scfp_pkg::REG_OP_ADC:       cfg.op_adc <= cfg_data;
        scfp_pkg::REG_OP_DAC:       cfg.op_dac <= cfg_data;
        scfp_pkg::REG_OP_SERIAL:    cfg.op_serial <= cfg_data;
        scfp_pkg::REG_OP_SD:        cfg.op_sd <= cfg_data;
        scfp_pkg::REG_CHECK_ENABLE: cfg.check_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Frame as it stands when the check byte arrives
  always_comb begin
    frame.command    = frame_command;
    frame.arg_length = arg_length;
    frame.xor_final  = running_xor ^ rx_byte;
    for (int i = 0; i < scfp_pkg::ARGS_USED; i++) begin
      frame.args[i] = arg_store[i];
    end
  end

  scfp_apply u_apply (
    .cfg    (cfg),
    .frame  (frame),
    .result (verdict)
  );

  always_comb begin
    parse_phase_next   = parse_phase;
    frame_command_next = frame_command;
    arg_length_next    = arg_length;
    arg_count_next     = arg_count;
    running_xor_next   = running_xor;
    channel_reg_next   = channel_reg;
    period_reg_next    = period_reg;
    print_flag_next    = print_flag;
    sd_flag_next       = sd_flag;
    frame_active_next  = frame_active;
    store_we           = 1'b0;
    is_check           = 1'b0;
    unique case (parse_phase)
      scfp_pkg::PH_START: begin
        if (rx_byte == cfg.start_byte) begin
          frame_active_next = 1'b1;
          running_xor_next  = rx_byte;
          parse_phase_next  = scfp_pkg::PH_CMD;
        end
      end
      scfp_pkg::PH_CMD: begin
        frame_command_next = rx_byte;
        running_xor_next   = running_xor ^ rx_byte;
        parse_phase_next   = scfp_pkg::PH_LEN;
      end
      scfp_pkg::PH_LEN: begin
        arg_length_next  = rx_byte;
        arg_count_next   = 8'd0;
        running_xor_next = running_xor ^ rx_byte;
        // zero-length frame goes straight to the check byte
        parse_phase_next = (rx_byte != 8'd0) ? scfp_pkg::PH_ARGS : scfp_pkg::PH_CHECK;
      end
      scfp_pkg::PH_ARGS: begin
        store_we         = (arg_count < 8'(scfp_pkg::STORED_ARGS));
        running_xor_next = running_xor ^ rx_byte;
        arg_count_next   = arg_count + 8'd1;
        if (arg_count_next == arg_length) begin
          parse_phase_next = scfp_pkg::PH_CHECK;
        end
      end
      scfp_pkg::PH_CHECK: begin
        is_check          = 1'b1;
        running_xor_next  = running_xor ^ rx_byte;
        parse_phase_next  = scfp_pkg::PH_START;
        frame_active_next = 1'b0;
        if (verdict.channel_we) channel_reg_next = verdict.channel;
        if (verdict.period_we)  period_reg_next  = verdict.period;
        if (verdict.print_we)   print_flag_next  = verdict.print_val;
        if (verdict.sd_we)      sd_flag_next     = verdict.sd_val;
      end
      default: begin
        parse_phase_next  = scfp_pkg::PH_START;
        frame_active_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase   <= scfp_pkg::PH_START;
      frame_command <= 8'd0;
      arg_length    <= 8'd0;
      arg_count     <= 8'd0;
      running_xor   <= 8'd0;
      channel_reg   <= 3'd0;
      period_reg    <= scfp_pkg::PERIOD_RESET;
      print_flag    <= 1'b1;
      sd_flag       <= 1'b0;
      frame_active  <= 1'b0;
    end else if (accept) begin
      parse_phase   <= parse_phase_next;
      frame_command <= frame_command_next;
      arg_length    <= arg_length_next;
      arg_count     <= arg_count_next;
      running_xor   <= running_xor_next;
      channel_reg   <= channel_reg_next;
      period_reg    <= period_reg_next;
      print_flag    <= print_flag_next;
      sd_flag       <= sd_flag_next;
      frame_active  <= frame_active_next;
    end
  end

  // Argument bytes past the stored depth only feed the XOR
  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      arg_store[arg_count[scfp_pkg::ARG_IDX_W-1:0]] <= rx_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_frame     <= frame_active_next;
      frame_end    <= is_check;
      status       <= is_check ? verdict.status : scfp_pkg::ST_NONE;
      led_write    <= is_check && verdict.led_write;
      led_index    <= is_check ? verdict.led_index : 2'd0;
      led_on       <= is_check && verdict.led_on;
      adc_channel  <= channel_reg_next;
      adc_period   <= period_reg_next;
      print_enable <= print_flag_next;
      sd_enable    <= sd_flag_next;
    end
  end

`include "serial_command_frame_parser_unit_assert.svh"

  `SCFP_ASSERT_NOW(a_status_only_at_end, out_valid && !frame_end, status == scfp_pkg::ST_NONE && !led_write)
  `SCFP_ASSERT_NOW(a_led_needs_applied, out_valid && led_write, status == scfp_pkg::ST_APPLIED)
  `SCFP_ASSERT_NOW(a_end_closes_frame, out_valid && frame_end, !in_frame)
  `SCFP_ASSERT_NEXT(a_check_ends_frame, accept && parse_phase == scfp_pkg::PH_CHECK, parse_phase == scfp_pkg::PH_START && !frame_active)

endmodule

@@ tb/serial_command_frame_parser_unit_tb.sv @@
// Testbench for the serial command frame parser: frame traffic, live prediction, result check.
`timescale 1ns / 1ps

module serial_command_frame_parser_unit_tb;
  import scfp_pkg::*;

  localparam int TIMEOUT_CYCLES = 200000;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef logic [7:0] bytes_t [];

  typedef struct packed {
    logic        in_frame;
    logic        frame_end;
    logic [2:0]  status;
    logic        led_write;
    logic [1:0]  led_index;
    logic        led_on;
    logic [2:0]  adc_channel;
    logic [29:0] adc_period;
    logic        print_enable;
    logic        sd_enable;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = REG_START_BYTE;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        in_frame;
  logic        frame_end;
  logic [2:0]  status;
  logic        led_write;
  logic [1:0]  led_index;
  logic        led_on;
  logic [2:0]  adc_channel;
  logic [29:0] adc_period;
  logic        print_enable;
  logic        sd_enable;

  // Predictor copy of the configuration and the parse state
  cfg_t        cfg_now;
  logic [2:0]  cur_phase;
  logic [7:0]  cur_cmd;
  logic [7:0]  arg_len;
  logic [7:0]  arg_cnt;
  logic [7:0]  arg_bytes [STORED_ARGS];
  logic [7:0]  frame_xor;
  logic [2:0]  chan_now;
  logic [29:0] period_now;
  logic        print_now;
  logic        sd_now;
  logic        frame_open;

  logic [7:0]    rx_bytes_q [$];
  parse_result_t pending_results [$];

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   mismatch_cnt = 0;
  int   frame_bytes = 0;
  int   cycle_cnt = 0;
  int   hold_left = 0;
  logic hold_kick = 1'b0;

  serial_command_frame_parser_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .in_frame     (in_frame),
    .frame_end    (frame_end),
    .status       (status),
    .led_write    (led_write),
    .led_index    (led_index),
    .led_on       (led_on),
    .adc_channel  (adc_channel),
    .adc_period   (adc_period),
    .print_enable (print_enable),
    .sd_enable    (sd_enable)
  );

  always #6 clk = ~clk;

  // Advances the parse state by one byte and returns the result it produces.
  function automatic parse_result_t parse_rx_byte(input logic [7:0] b);
    parse_result_t r;
    logic [31:0]   per;
    r = '0;
    case (cur_phase)
      PH_START: begin
        if (b == cfg_now.start_byte) begin
          frame_open = 1'b1;
          frame_xor = b;
          cur_phase = PH_CMD;
        end
      end
      PH_CMD: begin
        cur_cmd = b;
        frame_xor ^= b;
        cur_phase = PH_LEN;
      end
      PH_LEN: begin
        arg_len = b;
        arg_cnt = 8'd0;
        frame_xor ^= b;
        cur_phase = (b != 8'd0) ? PH_ARGS : PH_CHECK;
      end
      PH_ARGS: begin
        if (arg_cnt < STORED_ARGS) arg_bytes[arg_cnt] = b;
        frame_xor ^= b;
        arg_cnt = arg_cnt + 8'd1;
        if (arg_cnt == arg_len) cur_phase = PH_CHECK;
      end
      default: begin
        frame_xor ^= b;
        r.frame_end = 1'b1;
        if (cfg_now.check_enable && frame_xor != 8'd0) begin
          r.status = ST_BADCHK;
        end else if (cur_cmd == cfg_now.op_led) begin
          if (arg_len < LED_ARGS) begin
            r.status = ST_SHORT;
          end else begin
            r.status = ST_APPLIED;
            // LED numbers past the last one are accepted but request nothing
            if (arg_bytes[0] < LED_COUNT) begin
              r.led_write = 1'b1;
              r.led_index = arg_bytes[0][1:0];
              r.led_on = (arg_bytes[1] != 8'd0);
            end
          end
        end else if (cur_cmd == cfg_now.op_adc) begin
          if (arg_len < ADC_ARGS) begin
            r.status = ST_SHORT;
          end else begin
            r.status = ST_APPLIED;
            per = {arg_bytes[4], arg_bytes[3], arg_bytes[2], arg_bytes[1]};
            if (arg_bytes[0] < CHANNEL_COUNT) chan_now = arg_bytes[0][2:0];
            if (per != 32'd0 && per < PERIOD_LIMIT) period_now = per[29:0];
          end
        end else if (cur_cmd == cfg_now.op_dac) begin
          r.status = (arg_len < DAC_ARGS) ? ST_SHORT : ST_APPLIED;
        end else if (cur_cmd == cfg_now.op_serial) begin
          if (arg_len < SERIAL_ARGS) begin
            r.status = ST_SHORT;
          end else begin
            r.status = ST_APPLIED;
            print_now = (arg_bytes[0] != 8'd0);
          end
        end else if (cur_cmd == cfg_now.op_sd) begin
          if (arg_len < SD_ARGS) begin
            r.status = ST_SHORT;
          end else begin
            r.status = ST_APPLIED;
            sd_now = (arg_bytes[0] != 8'd0);
          end
        end else begin
          r.status = ST_UNKNOWN;
        end
        cur_phase = PH_START;
        frame_open = 1'b0;
      end
    endcase
    r.in_frame = frame_open;
    r.adc_channel = chan_now;
    r.adc_period = period_now;
    r.print_enable = print_now;
    r.sd_enable = sd_now;
    return r;
  endfunction

  function automatic string show_result(input parse_result_t r);
    return $sformatf("frm=%0d end=%0d st=%0d led=%0d/%0d/%0d ch=%0d per=%0d pr=%0d sd=%0d",
                     r.in_frame, r.frame_end, r.status, r.led_write, r.led_index, r.led_on,
                     r.adc_channel, r.adc_period, r.print_enable, r.sd_enable);
  endfunction

  // Driver: presents queued bytes, predicts each accepted request
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pending_results.push_back(parse_rx_byte(rx_byte));
      if (!in_valid || in_ready) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver hold-off counter
  always @(posedge clk) begin
    if (hold_kick) hold_left <= HOLD_OFF_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: checks each taken result against the oldest prediction
  always @(posedge clk) begin : mon
    parse_result_t got;
    parse_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {in_frame, frame_end, status, led_write, led_index, led_on,
               adc_channel, adc_period, print_enable, sd_enable};
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result: %s", show_result(got));
        end else begin
          want = pending_results.pop_front();
          if (got.in_frame !== want.in_frame || got.frame_end !== want.frame_end ||
              got.status !== want.status || got.led_write !== want.led_write ||
              got.led_index !== want.led_index || got.led_on !== want.led_on ||
              got.adc_channel !== want.adc_channel || got.adc_period !== want.adc_period ||
              got.print_enable !== want.print_enable || got.sd_enable !== want.sd_enable)
          begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: exp %s", show_result(want));
              $display("          got %s", show_result(got));
            end
          end
        end
      end
      out_ready <= (hold_left == 0) && !hold_kick && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= TIMEOUT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_START_BYTE:   cfg_now.start_byte = val;
      REG_OP_LED:       cfg_now.op_led = val;
      REG_OP_ADC:       cfg_now.op_adc = val;
      REG_OP_DAC:       cfg_now.op_dac = val;
      REG_OP_SERIAL:    cfg_now.op_serial = val;
      REG_OP_SD:        cfg_now.op_sd = val;
      REG_CHECK_ENABLE: cfg_now.check_enable = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] sb, input logic [7:0] led, input logic [7:0] adc,
                            input logic [7:0] dac, input logic [7:0] ser, input logic [7:0] sd,
                            input logic ce);
    write_reg(REG_START_BYTE, sb);
    write_reg(REG_OP_LED, led);
    write_reg(REG_OP_ADC, adc);
    write_reg(REG_OP_DAC, dac);
    write_reg(REG_OP_SERIAL, ser);
    write_reg(REG_OP_SD, sd);
    write_reg(REG_CHECK_ENABLE, {7'd0, ce});
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_frame(input logic [7:0] cmd, input bytes_t args, input logic corrupt);
    logic [7:0] chk;
    chk = cfg_now.start_byte ^ cmd ^ 8'(args.size());
    rx_bytes_q.push_back(cfg_now.start_byte);
    rx_bytes_q.push_back(cmd);
    rx_bytes_q.push_back(8'(args.size()));
    foreach (args[i]) begin
      rx_bytes_q.push_back(args[i]);
      chk ^= args[i];
    end
    if (corrupt) chk ^= 8'($urandom_range(255, 1));
    rx_bytes_q.push_back(chk);
    frame_bytes += 4 + args.size();
  endtask

  // Mostly well-formed frames with shaped arguments, plus line noise and cut-off frames
  task automatic push_random_frame();
    logic [7:0] cmd;
    int         need;
    int         len;
    int         pick;
    int         shape;
    bytes_t     a;
    if ($urandom_range(9) < 3)
      repeat ($urandom_range(3, 1)) rx_bytes_q.push_back(8'($urandom));
    if ($urandom_range(19) == 0) begin
      rx_bytes_q.push_back(cfg_now.start_byte);
      repeat ($urandom_range(2)) rx_bytes_q.push_back(8'($urandom));
    end
    pick = $urandom_range(9);
    case (pick)
      0, 1: begin cmd = cfg_now.op_led; need = LED_ARGS; end
      2, 3: begin cmd = cfg_now.op_adc; need = ADC_ARGS; end
      4: begin cmd = cfg_now.op_dac; need = DAC_ARGS; end
      5: begin cmd = cfg_now.op_serial; need = SERIAL_ARGS; end
      6: begin cmd = cfg_now.op_sd; need = SD_ARGS; end
      default: begin cmd = 8'($urandom); need = $urandom_range(3); end
    endcase
    shape = $urandom_range(19);
    if (shape < 13) len = need;
    else if (shape < 16) len = $urandom_range(need);
    else if (shape < 19) len = $urandom_range(12);
    else len = $urandom_range(40);
    a = new[len];
    foreach (a[i]) a[i] = 8'($urandom);
    if (len > 0) begin
      if (pick < 2) begin
        a[0] = 8'($urandom_range(5));
        if (len > 1 && $urandom_range(1) == 0) a[1] = 8'd0;
      end else if (pick < 4) begin
        if ($urandom_range(3) != 0) a[0] = 8'($urandom_range(9));
        if (len >= 5) begin
          case ($urandom_range(7))
            0: {a[4], a[3], a[2], a[1]} = 32'd999999999;
            1: {a[4], a[3], a[2], a[1]} = 32'd1000000000;
            2: {a[4], a[3], a[2], a[1]} = 32'd0;
            3, 4, 5: a[4] = 8'($urandom_range(8'h3b));
            default: ;
          endcase
        end
      end else if (pick < 7) begin
        if ($urandom_range(1) == 0) a[0] = 8'd0;
      end
    end
    push_frame(cmd, a, $urandom_range(99) < 15);
  endtask

  // Waits until every byte is sent and every predicted result has been taken
  task automatic wait_idle();
    do @(negedge clk);
    while (rx_bytes_q.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic kick_hold_off();
    @(posedge clk);
    hold_kick <= 1'b1;
    @(posedge clk);
    hold_kick <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    bytes_t a;
    int     target;
    cfg_now = '{8'd126, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 1'b1};
    cur_phase = PH_START;
    cur_cmd = 8'd0;
    arg_len = 8'd0;
    arg_cnt = 8'd0;
    foreach (arg_bytes[i]) arg_bytes[i] = 8'd0;
    frame_xor = 8'd0;
    chan_now = 3'd0;
    period_now = PERIOD_RESET;
    print_now = 1'b1;
    sd_now = 1'b0;
    frame_open = 1'b0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin send_idle_pct = 56; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 56; end
        3: begin send_idle_pct = 11; recv_stall_pct = 11; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      case (p)
        1: set_config(8'h00, 8'hff, 8'h80, 8'h7f, 8'h00, 8'h01, 1'b0);
        // colliding codes: LED beats ADC, DAC beats serial
        2: set_config(8'hff, 8'h10, 8'h10, 8'h20, 8'h20, 8'h30, 1'b1);
        3: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom), 1'($urandom));
        4: set_config(8'd126, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 1'b1);
        default: ;
      endcase
      frame_bytes = 0;
      target = (p == 0) ? 150 : 190;
      if (p == 0) begin
        a.delete();
        push_frame(cfg_now.op_serial, a, 1'b0);
        a = '{8'd3, 8'd1};
        push_frame(cfg_now.op_led, a, 1'b0);
        a = '{8'd4, 8'hff};
        push_frame(cfg_now.op_led, a, 1'b0);
        a = '{8'd7, 8'hff, 8'hc9, 8'h9a, 8'h3b};
        push_frame(cfg_now.op_adc, a, 1'b0);
        wait_idle();
        frame_bytes = 0;
      end
      if (p == 1 || p == 2) kick_hold_off();
      if (p == 1 || p == 3) begin
        a = new[(p == 1) ? 255 : $urandom_range(200, 128)];
        foreach (a[i]) a[i] = 8'($urandom);
        push_frame((p == 1) ? cfg_now.op_adc : cfg_now.op_led, a, 1'b0);
      end
      while (frame_bytes < target / 2) push_random_frame();
      wait_idle();
      while (frame_bytes < target) push_random_frame();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/scfp_pkg.sv
sv/scfp_apply.sv
sv/serial_command_frame_parser_unit.sv
tb/serial_command_frame_parser_unit_tb.sv
